>>> rtl/core/fctc_pkg.sv
// Shared types, codes and constants of the four-channel toggle counter command slave.
package fctc_pkg;

    localparam int NUM_CH    = 4;
    localparam int CNT_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [BYTE_W-1:0] CMD_BLANK = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_IDENT = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_LOAD  = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h10;
    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_SWAP_PLUG_ONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_PLUG_TWO = 1'd1;

    localparam logic [IDX_W-1:0] IDX_ZERO_LAST  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_IDENT_LAST = 4'd6;
    localparam logic [IDX_W-1:0] IDX_SNAP_LAST  = 4'd15;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_IDENT,
        KIND_SNAP
    } reply_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic              item_go;
        logic              read_go;
        logic              load_out;
        logic              out_last;
        reply_kind_t       kind;
        logic [IDX_W-1:0]  byte_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        reply_kind_t cmd_kind;
        logic        out_free;
    } dp_status_t;

    function automatic logic [BYTE_W-1:0] ident_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h6F;
            3'd1:    b = 8'h64;
            3'd2:    b = 8'h73;
            3'd3:    b = 8'h70;
            3'd4:    b = 8'h30;
            3'd5:    b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/fctc_ctrl.sv
// Controller: accepts requests and sequences the reply bytes of a read request.
module fctc_ctrl
    import fctc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] op,
    input  dp_status_t      status,
    output logic            s_tready,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t       state_reg, state_next;
    reply_kind_t       kind_reg, kind_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  idx_last;

    always_comb begin
        case (kind_reg)
            KIND_IDENT: idx_last = IDX_IDENT_LAST;
            KIND_SNAP:  idx_last = IDX_SNAP_LAST;
            default:    idx_last = IDX_ZERO_LAST;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && op == OP_READ) begin
                    state_next = ST_SEND;
                    kind_next  = status.cmd_kind;
                    idx_next   = '0;
                end
            end
            ST_SEND: begin
                if (status.out_free) begin
                    if (idx_reg == idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd.item_go  = 1'b0;
        cmd.read_go  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.out_last = (idx_reg == idx_last);
        cmd.kind     = kind_reg;
        cmd.byte_idx = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.read_go = s_tvalid && (op == OP_READ);
                cmd.item_go = s_tvalid && (op != OP_READ);
            end
            ST_SEND: begin
                cmd.load_out = status.out_free;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_ZERO;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> rtl/core/fctc_datapath.sv
// Datapath: counters, snapshot, command and load-value registers, output register.
module fctc_datapath
    import fctc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    input  logic [OP_W-1:0]      op,
    input  logic [NUM_CH-1:0]    pin_levels,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 rx_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  logic                 m_tready,
    output dp_status_t           status,
    output logic                 m_tvalid,
    output logic [BYTE_W-1:0]    tx_byte,
    output logic                 tx_last
);

    logic                swap_one_reg, swap_one_next;
    logic                swap_two_reg, swap_two_next;
    logic [BYTE_W-1:0]   command_reg, command_next;
    logic                draining_reg, draining_next;
    logic [1:0]          vcount_reg, vcount_next;
    logic [23:0]         partial_reg, partial_next;
    logic [CNT_W-1:0]    cnt_reg [NUM_CH];
    logic [CNT_W-1:0]    cnt_next [NUM_CH];
    logic [NUM_CH-1:0]   lvl_reg, lvl_next;
    logic [CNT_W-1:0]    snap_reg [NUM_CH];
    logic [CNT_W-1:0]    snap_next [NUM_CH];
    logic                mvalid_reg, mvalid_next;
    logic [BYTE_W-1:0]   txb_reg, txb_next;
    logic                txl_reg, txl_next;
    logic [CNT_W-1:0]    load_val;
    logic [CNT_W-1:0]    snap_word;
    logic [BYTE_W-1:0]   snap_byte;

    always_comb begin
        if (command_reg == CMD_IDENT) begin
            status.cmd_kind = KIND_IDENT;
        end else if (command_reg == CMD_READ) begin
            status.cmd_kind = KIND_SNAP;
        end else begin
            status.cmd_kind = KIND_ZERO;
        end
        status.out_free = !mvalid_reg || m_tready;
    end

    always_comb begin
        case (vcount_reg)
            2'd0:    load_val = {rx_byte, FILL_BYTE, FILL_BYTE, FILL_BYTE};
            2'd1:    load_val = {partial_reg[7:0], rx_byte, FILL_BYTE, FILL_BYTE};
            2'd2:    load_val = {partial_reg[15:0], rx_byte, FILL_BYTE};
            default: load_val = {partial_reg, rx_byte};
        endcase
    end

    // state update per accepted request and configuration write
    always_comb begin
        swap_one_next = swap_one_reg;
        swap_two_next = swap_two_reg;
        command_next  = command_reg;
        draining_next = draining_reg;
        vcount_next   = vcount_reg;
        partial_next  = partial_reg;
        cnt_next      = cnt_reg;
        lvl_next      = lvl_reg;
        snap_next     = snap_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_SWAP_PLUG_ONE: swap_one_next = cfg_data;
                default:           swap_two_next = cfg_data;
            endcase
        end

        if (cmd.read_go) begin
            draining_next = 1'b0;
            vcount_next   = '0;
            partial_next  = '0;
            command_next  = CMD_BLANK;
        end

        if (cmd.item_go) begin
            case (op)
                OP_SAMPLE: begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (pin_levels[i] != lvl_reg[i]) begin
                            lvl_next[i] = pin_levels[i];
                            cnt_next[i] = cnt_reg[i] + CNT_W'(1);
                        end
                    end
                    if (swap_one_reg) begin
                        snap_next[0] = cnt_next[1];
                        snap_next[1] = cnt_next[0];
                    end else begin
                        snap_next[0] = cnt_next[0];
                        snap_next[1] = cnt_next[1];
                    end
                    if (swap_two_reg) begin
                        snap_next[2] = cnt_next[3];
                        snap_next[3] = cnt_next[2];
                    end else begin
                        snap_next[2] = cnt_next[2];
                        snap_next[3] = cnt_next[3];
                    end
                end
                OP_BYTE: begin
                    if (draining_reg) begin
                        if (rx_last) begin
                            draining_next = 1'b0;
                            command_next  = CMD_BLANK;
                        end
                    end else if (command_reg == CMD_BLANK) begin
                        command_next = rx_byte;
                        vcount_next  = '0;
                        partial_next = '0;
                    end else if (command_reg == CMD_LOAD
                                 && vcount_reg != 2'd3 && !rx_last) begin
                        partial_next = {partial_reg[15:0], rx_byte};
                        vcount_next  = vcount_reg + 2'd1;
                    end else begin
                        if (command_reg == CMD_LOAD) begin
                            for (int i = 0; i < NUM_CH; i++) begin
                                cnt_next[i] = load_val;
                            end
                        end
                        command_next  = CMD_BLANK;
                        vcount_next   = '0;
                        partial_next  = '0;
                        draining_next = !rx_last;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // reply byte and output register
    always_comb begin
        snap_word = snap_reg[cmd.byte_idx[3:2]];
        case (cmd.byte_idx[1:0])
            2'd0:    snap_byte = snap_word[31:24];
            2'd1:    snap_byte = snap_word[23:16];
            2'd2:    snap_byte = snap_word[15:8];
            default: snap_byte = snap_word[7:0];
        endcase

        mvalid_next = mvalid_reg && !m_tready;
        txb_next    = txb_reg;
        txl_next    = txl_reg;
        if (cmd.load_out) begin
            mvalid_next = 1'b1;
            txl_next    = cmd.out_last;
            case (cmd.kind)
                KIND_IDENT: txb_next = ident_byte(cmd.byte_idx[2:0]);
                KIND_SNAP:  txb_next = snap_byte;
                default:    txb_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_one_reg <= 1'b0;
            swap_two_reg <= 1'b0;
            command_reg  <= CMD_BLANK;
            draining_reg <= 1'b0;
            vcount_reg   <= '0;
            partial_reg  <= '0;
            lvl_reg      <= '0;
            mvalid_reg   <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                cnt_reg[i]  <= '0;
                snap_reg[i] <= '0;
            end
        end else begin
            swap_one_reg <= swap_one_next;
            swap_two_reg <= swap_two_next;
            command_reg  <= command_next;
            draining_reg <= draining_next;
            vcount_reg   <= vcount_next;
            partial_reg  <= partial_next;
            lvl_reg      <= lvl_next;
            mvalid_reg   <= mvalid_next;
            cnt_reg      <= cnt_next;
            snap_reg     <= snap_next;
        end
        txb_reg <= txb_next;
        txl_reg <= txl_next;
    end

    assign m_tvalid = mvalid_reg;
    assign tx_byte  = txb_reg;
    assign tx_last  = txl_reg;

endmodule

>>> rtl/core/four_channel_toggle_counter_cmd_slave.sv
// Top level of the four-channel toggle counter with byte command slave.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+---------------------------------------
//   s_        | in        | s_tvalid / s_tready  | tuser operation, tdata levels+byte, tlast
//   m_        | out       | m_tvalid / m_tready  | tdata tx_byte, tlast tx_last
//   cfg_      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A new request is taken every cycle, except while the reply of a read request is being sent.
// A read request gives N reply bytes (1, 7 or 16), one byte per cycle
// through the single output register; m_tready low holds the bytes back.
// The next request is taken while the final reply byte still waits in the output register.
// Synchronous aresetn reset clears all but the output data at once; no clearing pass.
module four_channel_toggle_counter_cmd_slave
    import fctc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [3:0] pin_levels, [11:4] rx_byte, [15:12] zero
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] operation
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,   // [7:0] tx_byte
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fctc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    fctc_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .op         (s_tuser),
        .pin_levels (s_tdata[3:0]),
        .rx_byte    (s_tdata[11:4]),
        .rx_last    (s_tlast),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .tx_byte    (m_tdata),
        .tx_last    (m_tlast)
    );

endmodule
